// ===== rtl/core/msp_pkg.sv =====
// Shared widths, codes and types of the move speed planner.
package msp_pkg;

    localparam int DIST_W     = 32;  // Q16.16 axis distance
    localparam int NORM_W     = 32;  // Q16.16 move norm
    localparam int SPD_W      = 16;  // Q12.4 speed
    localparam int SQ_W       = 64;  // squared distance magnitude
    localparam int SUM_W      = 66;  // exact sum of up to four squares
    localparam int ROOT_W     = 33;  // integer square root of the sum
    localparam int NUM_W      = 48;  // speed times norm
    localparam int MAX_AXES   = 4;
    localparam int MAX_GROUPS = 4;
    localparam int MASK_W     = 4;   // mask bits per group
    localparam int GRP_W      = 2;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_W       = 160;
    localparam int OUT_W      = 24;

    typedef enum logic [1:0] {
        ST_SELECTED = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_NONE     = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEL   = 2'd0,
        REG_MASKS = 2'd1,
        REG_GSPD  = 2'd2,
        REG_AMAX  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              found;
        logic [GRP_W-1:0]  used;
        t_status           status;
    } t_plan_tag;

endpackage

// ===== rtl/core/msp_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module msp_isqrt
    import msp_pkg::*;
#(
    parameter int SB_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [SB_W-1:0]   i_sb,
    output logic [ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]   o_sb
);

    localparam int TW = SUM_W + 2;

    logic [SUM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SB_W-1:0]   r_sb   [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_st
            localparam int BIT = ROOT_W - 1 - j;
            logic [SUM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SB_W-1:0]   sb_in;
            logic [TW-1:0]     trial;
            logic [SUM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;

            if (j == 0) begin : g_first
                assign rem_in  = i_sum;
                assign root_in = '0;
                assign sb_in   = i_sb;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign sb_in   = r_sb[j-1];
            end

            // try setting this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
            always_comb begin
                trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
                if (TW'(rem_in) >= trial) begin
                    n_rem  = SUM_W'(TW'(rem_in) - trial);
                    n_root = root_in | (ROOT_W'(1) << BIT);
                end else begin
                    n_rem  = rem_in;
                    n_root = root_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= n_rem;
                    r_root[j] <= n_root;
                    r_sb[j]   <= sb_in;
                end
            end
        end
    endgenerate

    assign o_root = r_root[ROOT_W-1];
    assign o_sb   = r_sb[ROOT_W-1];

endmodule

// ===== rtl/core/msp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module msp_div
    import msp_pkg::*;
#(
    parameter int NW   = 48,
    parameter int DW   = 32,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    input  logic [SB_W-1:0] i_sb,
    output logic [NW-1:0]   o_quo,
    output logic [SB_W-1:0] o_sb
);

    logic [NW-1:0]   r_num [NW];
    logic [DW-1:0]   r_den [NW];
    logic [DW-1:0]   r_rem [NW];
    logic [NW-1:0]   r_quo [NW];
    logic [SB_W-1:0] r_sb  [NW];

    genvar j;
    generate
        for (j = 0; j < NW; j++) begin : g_st
            localparam int BIT = NW - 1 - j;
            logic [NW-1:0]   num_in;
            logic [DW-1:0]   den_in;
            logic [DW-1:0]   rem_in;
            logic [NW-1:0]   quo_in;
            logic [SB_W-1:0] sb_in;
            logic [DW:0]     part;
            logic [DW-1:0]   n_rem;
            logic [NW-1:0]   n_quo;

            if (j == 0) begin : g_first
                assign num_in = i_num;
                assign den_in = i_den;
                assign rem_in = '0;
                assign quo_in = '0;
                assign sb_in  = i_sb;
            end else begin : g_next
                assign num_in = r_num[j-1];
                assign den_in = r_den[j-1];
                assign rem_in = r_rem[j-1];
                assign quo_in = r_quo[j-1];
                assign sb_in  = r_sb[j-1];
            end

            // shift in the next numerator bit, subtract when it fits
            always_comb begin
                part = {rem_in, num_in[BIT]};
                if (part >= {1'b0, den_in}) begin
                    n_rem = DW'(part - {1'b0, den_in});
                    n_quo = quo_in | (NW'(1) << BIT);
                end else begin
                    n_rem = DW'(part);
                    n_quo = quo_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[j] <= num_in;
                    r_den[j] <= den_in;
                    r_rem[j] <= n_rem;
                    r_quo[j] <= n_quo;
                    r_sb[j]  <= sb_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NW-1];
    assign o_sb  = r_sb[NW-1];

endmodule

// ===== rtl/core/msp_outbuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result stream.
module msp_outbuf
    import msp_pkg::*;
#(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_out_vld;
    logic [W-1:0] r_out;
    logic         r_skid_vld;
    logic [W-1:0] r_skid;
    logic         take;

    assign take    = r_out_vld && i_ready;
    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // hold a result that cannot leave in the skid slot, refill from it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_vld || take) begin
                r_out     <= i_data;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= i_data;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/move_speed_planner_top.sv =====
// Move speed planner: lane pipeline, square root, speed divider and merge.
//
// Accepts one move per clock while the output buffer has room and returns one
// planned speed per move, in order. The pipeline is made of the 33-stage square
// root pipeline followed by the 48-stage dividers (one for the group speed, one
// per axis lane for the axis clamp, running side by side), plus five front
// stages and one merge stage. A two-entry output buffer lets the planner keep
// taking moves while a result waits; input stalls only once both entries are
// full. Configuration is read live and should be written only while the planner
// is empty.
module move_speed_planner_top
    import msp_pkg::*;
#(
    parameter int NUM_AXES   = 4,
    parameter int NUM_GROUPS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // dist_axis0, dist_axis1, dist_axis2, dist_axis3, move_norm
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // planned_speed, group_used, plan_status, speed_limited, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata
);

    typedef struct packed {
        logic              act;
        logic [NUM_W-1:0]  num;
        logic [DIST_W-1:0] mag;
    } t_lane;

    localparam int PRE_ST  = 5;
    localparam int LAST_ST = PRE_ST + ROOT_W + NUM_W;
    localparam int LANE_W  = $bits(t_lane);
    localparam int TAG_W   = $bits(t_plan_tag);
    localparam int LANES_W = NUM_AXES * LANE_W;
    localparam int ISB_W   = TAG_W + NUM_W + LANES_W;

    // configuration registers
    logic [GRP_W-1:0]                 r_sel;
    logic [MAX_GROUPS*MASK_W-1:0]     r_masks;
    logic [MAX_GROUPS*SPD_W-1:0]      r_gspd;
    logic [MAX_AXES*SPD_W-1:0]        r_amax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_masks <= '0;
            r_gspd  <= '0;
            r_amax  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SEL:   r_sel   <= i_cfg_data[GRP_W-1:0];
                REG_MASKS: r_masks <= i_cfg_data[MAX_GROUPS*MASK_W-1:0];
                REG_GSPD:  r_gspd  <= i_cfg_data[MAX_GROUPS*SPD_W-1:0];
                REG_AMAX:  r_amax  <= i_cfg_data[MAX_AXES*SPD_W-1:0];
                default:   r_sel   <= r_sel;
            endcase
        end
    end

    // pipeline valid bits, advancing together while the buffer has room
    logic               en;
    logic [LAST_ST:0]   r_vld;

    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST_ST-1:0], s_axis_tvalid};
        end
    end

    // stage 0: magnitudes; stage 1: squares and axis limit products
    logic [DIST_W-1:0] r0_mag [NUM_AXES];
    logic [NORM_W-1:0] r0_norm;
    logic [SQ_W-1:0]   r1_sq  [NUM_AXES];
    t_lane             r1_lane [NUM_AXES];
    logic [NORM_W-1:0] r1_norm;

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_lane
            logic [DIST_W-1:0] dist_raw;
            logic [SPD_W-1:0]  lim;
            assign dist_raw = s_axis_tdata[DIST_W*a +: DIST_W];
            assign lim      = r_amax[SPD_W*a +: SPD_W];

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r0_mag[a]       <= dist_raw[DIST_W-1] ? (~dist_raw + DIST_W'(1))
                                                          : dist_raw;
                    r1_sq[a]        <= SQ_W'(r0_mag[a]) * SQ_W'(r0_mag[a]);
                    r1_lane[a].num  <= NUM_W'(lim) * NUM_W'(r0_norm);
                    r1_lane[a].mag  <= r0_mag[a];
                    r1_lane[a].act  <= (lim != '0) && (r0_mag[a] != '0);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_norm <= s_axis_tdata[MAX_AXES*DIST_W +: NORM_W];
            r1_norm <= r0_norm;
        end
    end

    // stage 2: per-group sums of squares, unused groups read as zero
    logic [SUM_W-1:0]  n_gsum [MAX_GROUPS];
    logic [SUM_W-1:0]  r2_gsum [MAX_GROUPS];
    t_lane             r2_lane [NUM_AXES];
    logic [NORM_W-1:0] r2_norm;

    always_comb begin
        for (int g = 0; g < MAX_GROUPS; g++) begin
            n_gsum[g] = '0;
            if (g < NUM_GROUPS) begin
                for (int x = 0; x < NUM_AXES; x++) begin
                    if (r_masks[MASK_W*g + x]) begin
                        n_gsum[g] = n_gsum[g] + SUM_W'(r1_sq[x]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_gsum <= n_gsum;
            r2_lane <= r1_lane;
            r2_norm <= r1_norm;
        end
    end

    // stage 3: pick the selected group or the lowest moving fallback
    t_plan_tag         n_tag;
    logic [SUM_W-1:0]  r3_sum;
    t_plan_tag         r3_tag;
    logic [SPD_W-1:0]  r3_gs;
    t_lane             r3_lane [NUM_AXES];
    logic [NORM_W-1:0] r3_norm;

    always_comb begin
        n_tag.found  = 1'b1;
        n_tag.used   = r_sel;
        n_tag.status = ST_SELECTED;
        if (r2_gsum[r_sel] == '0) begin
            n_tag.found  = 1'b0;
            n_tag.status = ST_FALLBACK;
            for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
                if (r2_gsum[g] != '0) begin
                    n_tag.found = 1'b1;
                    n_tag.used  = GRP_W'(g);
                end
            end
            if (!n_tag.found) begin
                n_tag.status = ST_NONE;
                n_tag.used   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sum  <= r2_gsum[n_tag.used];
            r3_tag  <= n_tag;
            r3_gs   <= r_gspd[SPD_W*int'(n_tag.used) +: SPD_W];
            r3_lane <= r2_lane;
            r3_norm <= r2_norm;
        end
    end

    // stage 4: group speed times norm
    logic [NUM_W-1:0]  r4_numer;
    logic [SUM_W-1:0]  r4_sum;
    t_plan_tag         r4_tag;
    t_lane             r4_lane [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_numer <= NUM_W'(r3_gs) * NUM_W'(r3_norm);
            r4_sum   <= r3_sum;
            r4_tag   <= r3_tag;
            r4_lane  <= r3_lane;
        end
    end

    // square root, carrying numerator, tag and lanes alongside
    logic [LANES_W-1:0] lanes_in;
    logic [ISB_W-1:0]   isq_sb_out;
    logic [ROOT_W-1:0]  root;

    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_pack
            assign lanes_in[LANE_W*a +: LANE_W] = r4_lane[a];
        end
    endgenerate

    msp_isqrt #(
        .SB_W (ISB_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r4_sum),
        .i_sb   ({r4_tag, r4_numer, lanes_in}),
        .o_root (root),
        .o_sb   (isq_sb_out)
    );

    // speed divider and one clamp divider per lane, in step
    logic [NUM_W-1:0]  spd_q;
    logic [TAG_W-1:0]  tag_q;
    t_plan_tag         tag_fin;
    logic [NUM_W-1:0]  clamp_q [NUM_AXES];
    logic [NUM_AXES-1:0] act_q;

    msp_div #(
        .NW   (NUM_W),
        .DW   (ROOT_W),
        .SB_W (TAG_W)
    ) u_div_spd (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (isq_sb_out[LANES_W +: NUM_W]),
        .i_den (root),
        .i_sb  (isq_sb_out[LANES_W + NUM_W +: TAG_W]),
        .o_quo (spd_q),
        .o_sb  (tag_q)
    );

    assign tag_fin = t_plan_tag'(tag_q);

    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_cdiv
            t_lane ln;
            assign ln = t_lane'(isq_sb_out[LANE_W*a +: LANE_W]);

            msp_div #(
                .NW   (NUM_W),
                .DW   (DIST_W),
                .SB_W (1)
            ) u_div_clamp (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (ln.num),
                .i_den (ln.mag),
                .i_sb  (ln.act),
                .o_quo (clamp_q[a]),
                .o_sb  (act_q[a])
            );
        end
    endgenerate

    // merge: smallest of the group speed and the active clamps wins, then saturate
    logic [NUM_W-1:0]  fs;
    logic [OUT_W-1:0]  n_fin;
    logic [OUT_W-1:0]  r_fin;
    logic [SPD_W-1:0]  sat;
    logic              lim_hit;

    always_comb begin
        fs = spd_q;
        for (int x = 0; x < NUM_AXES; x++) begin
            if (act_q[x] && (clamp_q[x] < fs)) begin
                fs = clamp_q[x];
            end
        end
        lim_hit = fs < spd_q;
        sat     = (fs > NUM_W'({SPD_W{1'b1}})) ? {SPD_W{1'b1}} : SPD_W'(fs);
        if (tag_fin.found) begin
            n_fin = OUT_W'({lim_hit, tag_fin.status, tag_fin.used, sat});
        end else begin
            n_fin = OUT_W'({1'b0, ST_NONE, GRP_W'(0), SPD_W'(0)});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= n_fin;
        end
    end

    msp_outbuf #(
        .W (OUT_W)
    ) u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[LAST_ST]),
        .i_data  (r_fin),
        .o_ready (en),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

// ===== rtl/core/msp_checker.sv =====
// Port-level checks of the move speed planner and their bind.
module msp_checker
    import msp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [SPD_W-1:0] spd;
    logic [GRP_W-1:0] used;
    logic [1:0]       status;
    logic             limited;

    assign spd     = m_axis_tdata[SPD_W-1:0];
    assign used    = m_axis_tdata[SPD_W +: GRP_W];
    assign status  = m_axis_tdata[SPD_W + GRP_W +: 2];
    assign limited = m_axis_tdata[SPD_W + GRP_W + 2];

    // a waiting result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a move with no moving group reports only the error code
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_NONE |-> spd == '0 && used == '0 && !limited)
        else $error("no-move result carries data");

    // input stalls only while a result is backed up
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // buffer fills only after a refused result
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without back pressure");

endmodule

bind move_speed_planner_top msp_checker u_msp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
